@@ rtl/core/sk64_pkg.sv @@
// ============================================================================
// sk64_pkg
// Shared types, constants and nibble S-box functions for the SKINNY-64 engine.
// ============================================================================
package sk64_pkg;

  localparam int MAX_ROUNDS = 40;
  localparam int KEY_IDX_W  = $clog2(MAX_ROUNDS);
  localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
  localparam int NUM_COLS   = 4;
  localparam int NUM_ROWS   = 4;
  localparam int ROW_W      = 16;
  localparam int RC_W       = 6;

  // round constant XORed into row 2 on every round
  localparam logic [ROW_W-1:0] ROUND_CONST = 16'h0020;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  // register indexes
  localparam logic REG_ROUND_COUNT = 1'b0;

  typedef logic [3:0] nib_t;

  // one column of the state, entry k is row k
  typedef nib_t [NUM_ROWS-1:0] col_t;

  // nibbles a cell hands around the ring for the row rotation
  typedef struct packed {
    nib_t row1;
    nib_t row2;
    nib_t row3;
  } sk64_link_t;

  typedef struct packed {
    logic load;     // take a new block into the cells
    logic step;     // apply one round
    logic decrypt;  // inverse round
    logic capture;  // copy the finished block to the output register
  } sk64_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } sk64_state_t;

  function automatic nib_t sbox4(input nib_t x);
    logic c0, c1, c2, c3;
    c0 = ~x[0];
    c1 = ~x[1];
    c2 = ~x[2];
    c3 = ~x[3];
    c0 = c0 ^ (c3 & c2);
    c3 = c3 ^ (c1 & c2);
    c2 = c2 ^ (c1 & c0);
    c1 = c1 ^ (c0 & c3);
    return {~c0, ~c3, ~c2, ~c1};
  endfunction

  function automatic nib_t inv_sbox4(input nib_t x);
    logic c0, c1, c2, c3;
    c0 = ~x[0];
    c1 = ~x[1];
    c2 = ~x[2];
    c3 = ~x[3];
    c0 = c0 ^ (c3 & c2);
    c1 = c1 ^ (c3 & c0);
    c2 = c2 ^ (c1 & c0);
    c3 = c3 ^ (c1 & c2);
    return {~c2, ~c1, ~c0, ~c3};
  endfunction

endpackage

@@ rtl/core/sk64_cell.sv @@
// ============================================================================
// sk64_cell
// One state column: S-box, key add and column mix, or their inverses, for one round per cycle while step is set.
// ============================================================================
module sk64_cell (
  input  logic                clk,
  input  sk64_pkg::sk64_ctl_t ctl,
  input  sk64_pkg::col_t      load_col,
  input  sk64_pkg::nib_t      key0,
  input  sk64_pkg::nib_t      key1,
  input  sk64_pkg::nib_t      rc,
  input  sk64_pkg::sk64_link_t from_next,
  input  sk64_pkg::sk64_link_t from_opp,
  input  sk64_pkg::sk64_link_t from_prev,
  output sk64_pkg::sk64_link_t to_link,
  output sk64_pkg::col_t      col
);
  import sk64_pkg::*;

  col_t col_next;
  col_t sb;
  col_t mi;
  nib_t r0, r1, r2, r3, a1, a2;

  always_comb begin
    for (int k = 0; k < NUM_ROWS; k++) begin
      sb[k] = sbox4(col[k]);
    end
    // inverse column mix
    mi[0] = col[1];
    mi[1] = col[1] ^ col[2] ^ col[3];
    mi[2] = col[1] ^ col[3];
    mi[3] = col[0] ^ col[3];

    if (ctl.decrypt) begin
      to_link = '{row1: mi[1], row2: mi[2], row3: mi[3]};
    end else begin
      to_link = '{row1: sb[1] ^ key1, row2: sb[2] ^ rc, row3: sb[3]};
    end

    // forward round: rotated rows arrive from the ring, then mix
    r0 = sb[0] ^ key0;
    r1 = from_next.row1;
    r2 = from_opp.row2;
    r3 = from_prev.row3;
    a1 = r1 ^ r2;
    a2 = r2 ^ r0;

    if (ctl.load) begin
      col_next = load_col;
    end else if (ctl.decrypt) begin
      col_next[0] = inv_sbox4(mi[0] ^ key0);
      col_next[1] = inv_sbox4(from_prev.row1 ^ key1);
      col_next[2] = inv_sbox4(from_opp.row2 ^ rc);
      col_next[3] = inv_sbox4(from_next.row3);
    end else begin
      col_next[0] = r3 ^ a2;
      col_next[1] = r0;
      col_next[2] = a1;
      col_next[3] = a2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) begin
      col <= col_next;
    end
  end

endmodule

@@ rtl/core/sk64_ctrl.sv @@
// ============================================================================
// sk64_ctrl
// Round sequencer and round-key memory.
// ============================================================================
module sk64_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [1:0]                  operation,
  input  logic [5:0]                  key_slot,
  input  logic [sk64_pkg::ROW_W-1:0]  key_first_row,
  input  logic [sk64_pkg::ROW_W-1:0]  key_second_row,
  input  logic [sk64_pkg::RC_W-1:0]   round_count,
  input  logic                        out_free,
  output sk64_pkg::sk64_ctl_t         ctl,
  output logic [2*sk64_pkg::ROW_W-1:0] key_word
);
  import sk64_pkg::*;

  sk64_state_t state, state_next;
  logic [CNT_W-1:0]     left;
  logic [CNT_W-1:0]     rounds_sat;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [KEY_IDX_W-1:0] rd_addr;
  logic                 rd_en;
  logic                 decrypt;
  logic                 accept;
  logic                 crypt_acc;
  logic                 wr_en;

  logic [2*ROW_W-1:0] key_mem [MAX_ROUNDS];

  always_comb begin
    if (7'(round_count) > 7'(MAX_ROUNDS)) begin
      rounds_sat = CNT_W'(MAX_ROUNDS);
    end else begin
      rounds_sat = CNT_W'(round_count);
    end
  end

  assign accept    = s_tvalid && s_tready;
  assign crypt_acc = accept && (operation inside {OP_ENC, OP_DEC});
  assign wr_en     = accept && (operation == OP_LOAD) && (7'(key_slot) < 7'(MAX_ROUNDS));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (crypt_acc) begin
          state_next = (rounds_sat == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (left == CNT_W'(1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = 1'b0;
    ctl.load    = 1'b0;
    ctl.step    = 1'b0;
    ctl.decrypt = decrypt;
    ctl.capture = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = key_idx;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ctl.load = crypt_acc;
        rd_en    = crypt_acc && (rounds_sat != '0);
        rd_addr  = (operation == OP_DEC) ? KEY_IDX_W'(rounds_sat - 1'b1) : '0;
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        rd_en    = (left > CNT_W'(1));
      end
      ST_FINISH: begin
        ctl.capture = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (crypt_acc) begin
      left    <= rounds_sat;
      decrypt <= (operation == OP_DEC);
      key_idx <= (operation == OP_DEC) ? KEY_IDX_W'(rounds_sat - 2'd2) : KEY_IDX_W'(1);
    end else if (state == ST_RUN) begin
      left    <= left - 1'b1;
      key_idx <= decrypt ? key_idx - 1'b1 : key_idx + 1'b1;
    end
  end

  // key memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[key_slot[KEY_IDX_W-1:0]] <= {key_second_row, key_first_row};
    end
    if (rd_en) begin
      key_word <= key_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/skinny64_block_cipher.sv @@
// ============================================================================
// skinny64_block_cipher
// SKINNY-64 encrypt/decrypt engine with a loadable round-key table.
// ============================================================================
// Words on the slave stream carry an operation in s_tuser. A load word
// writes one 32-bit round key (two 16-bit rows) into a 40-entry key memory
// and leaves the input ready for the next word. An encrypt or decrypt word
// carries a 64-bit block as four 16-bit rows and yields one word on the
// master stream; decrypt walks the keys from the last round down to the
// first. Operation code 3 is dropped. round_count (APB offset 0x0, reset
// 32, saturated at 40) sets the rounds per block. A block is loaded on
// accept, runs one round per cycle in the four-cell column ring and is
// handed to the output register when it is free, before the next accept.
// Each round's key read is registered and issued in the cycle before the
// round. Keys must be loaded before a block uses them; unloaded entries
// give undefined results. Configuration must be written only while the
// engine is idle; the block does not enforce this. The output register
// lets the next block start while the previous result waits for m_tready.
// ============================================================================
module skinny64_block_cipher (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // key_slot[5:0], key_first_row[21:6],
                                 // key_second_row[37:22], block_row_a[53:38],
                                 // block_row_b[69:54], block_row_c[85:70],
                                 // block_row_d[101:86], zero pad
  input  logic [1:0]   s_tuser,  // operation
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // out_row_a, out_row_b, out_row_c, out_row_d
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sk64_pkg::*;

  logic [RC_W-1:0]       round_count;
  logic [2*ROW_W-1:0]    key_word;
  logic [ROW_W-1:0]      key_first_row, key_second_row;
  logic [ROW_W-1:0]      in_row [NUM_ROWS];
  logic [5:0]            key_slot;
  sk64_ctl_t             ctl;
  sk64_link_t            link [NUM_COLS];
  col_t                  col  [NUM_COLS];
  logic                  out_valid;
  logic                  out_free;
  logic [4*ROW_W-1:0]    out_data;
  logic [4*ROW_W-1:0]    state_rows;

  // input unpacking
  assign key_slot       = s_tdata[5:0];
  assign key_first_row  = s_tdata[21:6];
  assign key_second_row = s_tdata[37:22];
  assign in_row[0]      = s_tdata[53:38];
  assign in_row[1]      = s_tdata[69:54];
  assign in_row[2]      = s_tdata[85:70];
  assign in_row[3]      = s_tdata[101:86];

  // APB: single register, writes on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= RC_W'(32);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROUND_COUNT)) begin
      round_count <= pwdata[RC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROUND_COUNT) ? {{(32-RC_W){1'b0}}, round_count} : '0;

  // sequencer and key memory
  sk64_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .operation      (s_tuser),
    .key_slot       (key_slot),
    .key_first_row  (key_first_row),
    .key_second_row (key_second_row),
    .round_count    (round_count),
    .out_free       (out_free),
    .ctl            (ctl),
    .key_word       (key_word)
  );

  // Ring of column cells. The row rotations become nibble hand-offs:
  // each cell sends rows 1..3 and picks them up from the cell one, two
  // or three places along, per direction.
  for (genvar j = 0; j < NUM_COLS; j++) begin : g_cell
    col_t load_col;
    for (genvar k = 0; k < NUM_ROWS; k++) begin : g_row
      assign load_col[k] = in_row[k][4*j +: 4];
      assign state_rows[k*ROW_W + 4*j +: 4] = col[j][k];
    end

    sk64_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_col  (load_col),
      .key0      (key_word[4*j +: 4]),
      .key1      (key_word[ROW_W + 4*j +: 4]),
      .rc        (ROUND_CONST[4*j +: 4]),
      .from_next (link[(j+1) % NUM_COLS]),
      .from_opp  (link[(j+2) % NUM_COLS]),
      .from_prev (link[(j+3) % NUM_COLS]),
      .to_link   (link[j]),
      .col       (col[j])
    );
  end

  // output register
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.capture) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      out_data <= state_rows;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

@@ rtl/core/sk64_checker.sv @@
// ============================================================================
// sk64_checker
// Port-level checks for the SKINNY-64 engine, bound to the top level.
// ============================================================================
module sk64_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);
  import sk64_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_ENC || s_tuser == OP_DEC)) |=> !s_tready)
    else $error("input taken while a block is in the rounds");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_LOAD) |=> s_tready)
    else $error("key load stalled the input");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_ROUND_COUNT)
      |=> (paddr[2] != REG_ROUND_COUNT) || (prdata[RC_W-1:0] == $past(pwdata[RC_W-1:0])))
    else $error("round count readback mismatch");

endmodule

bind skinny64_block_cipher sk64_checker u_sk64_checker (.*);
